>>> hw/rtl/pnn_pkg.sv
// package for the polygon normal block: widths, defaults and shared types
// used by the front accumulator, the ring queue and the normalizer
package pnn_pkg;
    localparam int CoordBits       = 24;
    localparam int MaxRingVertices = 4096;
    localparam int NormalFracBits  = 14;
    localparam int SumBits         = 64;
    localparam int OutBits         = 16;

    // one finished ring handed from front to back
    typedef struct packed {
        logic [SumBits-1:0] sum_x;
        logic [SumBits-1:0] sum_y;
        logic [SumBits-1:0] sum_z;
        logic               degen;
        logic               ovf;
        logic               flip;
    } t_ring;
endpackage

>>> hw/rtl/polygon_normal_newell.sv
// newell polygon normal: one vertex request per ring step, one normal per ring
// the accumulator takes each vertex through accept, edge, multiply and add, but only
// accepts the first vertex of a longer ring, and runs edge, multiply and add once more for
// the closing edge; it takes a new vertex only once the last is added. the normalizer runs a
// leading-one search, square root and three divisions; a 2-deep queue lets rings overlap
// reset: synchronous active low, clears ring sums, count and all handshakes
module polygon_normal_newell #(
    parameter int COORD_BITS        = pnn_pkg::CoordBits,
    parameter int MAX_RING_VERTICES = pnn_pkg::MaxRingVertices,
    parameter int NORMAL_FRAC_BITS  = pnn_pkg::NormalFracBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [(3*COORD_BITS+7)/8*8-1:0] s_axis_tdata, // vert_x, vert_y, vert_z
    input  logic        s_axis_tlast,                     // ring_end
    input  logic        s_axis_tuser,                     // flip
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,                     // norm_x, norm_y, norm_z
    output logic [1:0]  m_axis_tuser                      // degenerate, overflow
);
    localparam int OB = pnn_pkg::OutBits;

    logic f_valid, q_ready, q_valid, n_ready;
    pnn_pkg::t_ring f_ring, q_ring;
    logic [OB-1:0] w_nx, w_ny, w_nz;
    logic w_degen, w_ovf;

    pnn_front #(.COORD_BITS(COORD_BITS), .MAX_RING_VERTICES(MAX_RING_VERTICES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_x(s_axis_tdata[COORD_BITS-1:0]),
        .i_y(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_z(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_last(s_axis_tlast), .i_flip(s_axis_tuser),
        .o_valid(f_valid), .i_ready(q_ready), .o_ring(f_ring)
    );

    pnn_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(q_ready), .i_ring(f_ring),
        .o_valid(q_valid), .i_ready(n_ready), .o_ring(q_ring)
    );

    pnn_norm #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_norm (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(n_ready), .i_ring(q_ring),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_nx(w_nx), .o_ny(w_ny), .o_nz(w_nz), .o_degen(w_degen), .o_ovf(w_ovf)
    );

    assign m_axis_tdata = {w_nz, w_ny, w_nx};
    assign m_axis_tuser = {w_ovf, w_degen};
endmodule

>>> hw/rtl/pnn_front.sv
// front part: takes vertices and accumulates the newell sums of one ring
// depends on pnn_pkg; the multiply-add for each edge is split over stages
module pnn_front #(
    parameter int COORD_BITS        = pnn_pkg::CoordBits,
    parameter int MAX_RING_VERTICES = pnn_pkg::MaxRingVertices
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [COORD_BITS-1:0] i_z,
    input  logic                  i_last,
    input  logic                  i_flip,
    output logic                  o_valid,
    input  logic                  i_ready,
    output pnn_pkg::t_ring        o_ring
);
    localparam int SB = pnn_pkg::SumBits;
    localparam int CB = $clog2(MAX_RING_VERTICES + 2);
    localparam int DB = COORD_BITS + 1;

    typedef enum logic [2:0] {S_IN, S_EDGE, S_MUL, S_ACC, S_OUT} t_state;

    t_state r_state;
    logic [COORD_BITS-1:0] r_fx, r_fy, r_fz, r_px, r_py, r_pz, r_cx, r_cy, r_cz;
    logic [SB-1:0] r_sx, r_sy, r_sz;
    logic [CB-1:0] r_cnt;
    logic r_last, r_flip, r_close;
    logic signed [DB-1:0] r_d0, r_d1, r_d2, r_a0, r_a1, r_a2;
    logic signed [2*DB-1:0] r_p0, r_p1, r_p2;
    logic [COORD_BITS-1:0] w_nx, w_ny, w_nz;

    assign o_ready = (r_state == S_IN);
    assign o_valid = (r_state == S_OUT);

    // edge end point: the new vertex, or the first vertex for the closing edge
    assign w_nx = r_close ? r_fx : r_cx;
    assign w_ny = r_close ? r_fy : r_cy;
    assign w_nz = r_close ? r_fz : r_cz;

    always_comb begin
        o_ring.sum_x = r_sx;
        o_ring.sum_y = r_sy;
        o_ring.sum_z = r_sz;
        o_ring.ovf   = (r_cnt > CB'(MAX_RING_VERTICES));
        o_ring.degen = (r_cnt < CB'(3)) || (r_sx == '0 && r_sy == '0 && r_sz == '0);
        o_ring.flip  = r_flip;
    end

    // ring accumulation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cnt   <= '0;
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
            r_fx <= '0; r_fy <= '0; r_fz <= '0;
            r_px <= '0; r_py <= '0; r_pz <= '0;
            r_close <= 1'b0;
        end else begin
            case (r_state)
                S_IN: if (i_valid) begin
                    r_cx <= i_x; r_cy <= i_y; r_cz <= i_z;
                    r_last <= i_last; r_flip <= i_flip;
                    r_close <= 1'b0;
                    if (r_cnt <= CB'(MAX_RING_VERTICES)) r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '0) begin
                        r_fx <= i_x; r_fy <= i_y; r_fz <= i_z;
                        r_px <= i_x; r_py <= i_y; r_pz <= i_z;
                        r_state <= i_last ? S_EDGE : S_IN;
                        r_close <= i_last;
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_d0 <= DB'($signed(r_py)) - DB'($signed(w_ny));
                    r_a0 <= DB'($signed(r_pz)) + DB'($signed(w_nz));
                    r_d1 <= DB'($signed(r_pz)) - DB'($signed(w_nz));
                    r_a1 <= DB'($signed(r_px)) + DB'($signed(w_nx));
                    r_d2 <= DB'($signed(r_px)) - DB'($signed(w_nx));
                    r_a2 <= DB'($signed(r_py)) + DB'($signed(w_ny));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p0 <= r_d0 * r_a0;
                    r_p1 <= r_d1 * r_a1;
                    r_p2 <= r_d2 * r_a2;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sx <= r_sx + SB'(r_p0);
                    r_sy <= r_sy + SB'(r_p1);
                    r_sz <= r_sz + SB'(r_p2);
                    if (r_close) begin
                        r_state <= S_OUT;
                    end else begin
                        r_px <= r_cx; r_py <= r_cy; r_pz <= r_cz;
                        r_close <= r_last;
                        r_state <= r_last ? S_EDGE : S_IN;
                    end
                end
                S_OUT: if (i_ready) begin
                    r_sx <= '0; r_sy <= '0; r_sz <= '0;
                    r_cnt <= '0; r_close <= 1'b0;
                    r_state <= S_IN;
                end
                default: r_state <= S_IN;
            endcase
        end
    end
endmodule

>>> hw/rtl/pnn_queue.sv
// two-entry queue of finished rings between accumulator and normalizer
// depends on pnn_pkg for the ring record
module pnn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pnn_pkg::t_ring i_ring,
    output logic           o_valid,
    input  logic           i_ready,
    output pnn_pkg::t_ring o_ring
);
    pnn_pkg::t_ring r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_ring  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_ring;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> hw/rtl/pnn_norm.sv
// back part: scales the newell sum vector to unit length
// depends on pnn_pkg; square root and division run one bit per cycle
module pnn_norm #(
    parameter int NORMAL_FRAC_BITS = pnn_pkg::NormalFracBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pnn_pkg::t_ring                i_ring,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pnn_pkg::OutBits-1:0]   o_nx,
    output logic [pnn_pkg::OutBits-1:0]   o_ny,
    output logic [pnn_pkg::OutBits-1:0]   o_nz,
    output logic                          o_degen,
    output logic                          o_ovf
);
    localparam int SB = pnn_pkg::SumBits;
    localparam int OB = pnn_pkg::OutBits;
    localparam int MB = 30;                   // scaled magnitude below 2^30
    localparam int NB = MB + NORMAL_FRAC_BITS; // dividend width
    localparam int QB = NB + 1;
    localparam int QC = $clog2(QB + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQ, S_SUM, S_SQRT, S_DIV, S_DIVW, S_SIGN, S_OUT
    } t_state;

    t_state r_state;
    logic [SB-1:0] r_m [3];
    logic [2:0] r_neg;
    logic r_flip, r_degen, r_ovf;
    logic [6:0] r_top;
    logic [MB-1:0] r_sm [3];
    logic [2*MB-1:0] r_sq [3];
    logic [63:0] r_rem, r_root, r_bit;
    logic [1:0] r_ci;
    logic [QB-1:0] r_dvd, r_q;
    logic [MB:0] r_dr;
    logic [QC-1:0] r_qi;
    logic [OB-1:0] r_res [3];
    logic [SB-1:0] w_all, w_sum;
    logic [MB+1:0] w_trial;
    logic [SB-1:0] w_sh;
    logic [OB-1:0] w_q;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_nx = r_res[0];
    assign o_ny = r_res[1];
    assign o_nz = r_res[2];
    assign o_degen = r_degen;
    assign o_ovf = r_ovf;

    assign w_all = r_m[0] | r_m[1] | r_m[2];
    assign w_sum = r_root + r_bit;
    assign w_trial = {r_dr, r_dvd[QB-1]} ;
    // shifted magnitude of the component in turn
    assign w_sh = (r_top > 7'd29) ? (r_m[r_ci] >> (r_top - 7'd29))
                                  : (r_m[r_ci] << (7'd29 - r_top));
    assign w_q = (r_q > QB'(32767)) ? OB'(32767) : r_q[OB-1:0];

    // normalization sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_flip <= i_ring.flip; r_degen <= i_ring.degen;
                    r_ovf <= i_ring.ovf;
                    r_neg <= {i_ring.sum_z[SB-1], i_ring.sum_y[SB-1], i_ring.sum_x[SB-1]};
                    r_m[0] <= i_ring.sum_x[SB-1] ? -i_ring.sum_x : i_ring.sum_x;
                    r_m[1] <= i_ring.sum_y[SB-1] ? -i_ring.sum_y : i_ring.sum_y;
                    r_m[2] <= i_ring.sum_z[SB-1] ? -i_ring.sum_z : i_ring.sum_z;
                    r_top <= 7'd63;
                    r_ci <= 2'd0;
                    if (i_ring.degen) begin
                        r_res[0] <= '0; r_res[1] <= '0; r_res[2] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                // leading one search, one bit a cycle, then shift each component
                S_NORM: begin
                    if (r_top != 7'd0 && !w_all[r_top[5:0]]) begin
                        r_top <= r_top - 7'd1;
                    end else begin
                        r_sm[r_ci] <= w_sh[MB-1:0];
                        if (r_ci == 2'd2) begin
                            r_ci <= 2'd0;
                            r_state <= S_SQ;
                        end else begin
                            r_ci <= r_ci + 2'd1;
                        end
                    end
                end
                S_SQ: begin
                    r_sq[0] <= r_sm[0] * r_sm[0];
                    r_sq[1] <= r_sm[1] * r_sm[1];
                    r_sq[2] <= r_sm[2] * r_sm[2];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rem <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
                    r_root <= '0;
                    r_bit <= 64'd1 << 62;
                    r_state <= S_SQRT;
                end
                // bit-pair square root, one pair a cycle
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_ci <= 2'd0;
                        r_state <= S_DIV;
                    end else begin
                        if (r_rem >= w_sum) begin
                            r_rem <= r_rem - w_sum;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                // load dividend for one component
                S_DIV: begin
                    r_dvd <= QB'({r_sm[r_ci], {NORMAL_FRAC_BITS{1'b0}}})
                           + QB'(r_root[MB:1]);
                    r_dr <= '0;
                    r_q <= '0;
                    r_qi <= '0;
                    r_state <= S_DIVW;
                end
                // restoring division, one quotient bit a cycle
                S_DIVW: begin
                    if (r_qi == QC'(QB)) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_dvd <= r_dvd << 1;
                        if (w_trial >= (MB+2)'(r_root)) begin
                            r_dr <= (MB+1)'(w_trial - (MB+2)'(r_root));
                            r_q <= {r_q[QB-2:0], 1'b1};
                        end else begin
                            r_dr <= w_trial[MB:0];
                            r_q <= {r_q[QB-2:0], 1'b0};
                        end
                        r_qi <= r_qi + 1'b1;
                    end
                end
                S_SIGN: begin
                    r_res[r_ci] <= (r_neg[r_ci] != r_flip) ? -w_q : w_q;
                    if (r_ci == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ci <= r_ci + 2'd1;
                        r_state <= S_DIV;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
